FILE: rtl/lfu_cache_table_assert.svh
// ----------------------------------------------------------------------------
// LFU cache table assertion macros
// Concurrent assertion forms used by the table's datapath.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// expression holds at every clock edge outside reset
`define LCT_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define LCT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define LCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lct_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache table package
// Widths, codes, entry record and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lct_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);
   localparam int CAP_W       = 5;
   localparam int LIM_W       = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam int KEY_W       = 32;
   localparam int VALUE_W     = 31;
   localparam int COUNT_W     = 32;
   localparam int STAMP_W     = 48;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic load_req;
      logic scan;
      logic update;
      logic evict;
      logic insert;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic hit;
      logic need_insert;
      logic need_evict;
      logic out_free;
   } ctrl_status_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_DRAIN  = 7'b0000100,
      ST_DECIDE = 7'b0001000,
      ST_UPDATE = 7'b0010000,
      ST_EVICT  = 7'b0100000,
      ST_INSERT = 7'b1000000
   } state_type;

endpackage

FILE: rtl/lct_ctrl.sv
// ----------------------------------------------------------------------------
// LFU cache table controller
// Sequences accept, table scan, decision, table update and result load.
// ----------------------------------------------------------------------------
module lct_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lct_pkg::ctrl_status_type status,
   output lct_pkg::ctrl_cmd_type    cmd,
   output logic                     done
);

   lct_pkg::state_type state_ff;
   lct_pkg::state_type state_in;
   logic               done_ff;
   logic               done_in;

   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      cmd      = '0;
      case (state_ff)
         lct_pkg::ST_IDLE: begin
            if (done_ff) begin
               if (status.out_free) begin
                  cmd.load_rsp = 1'b1;
                  done_in      = 1'b0;
               end
            end else if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = lct_pkg::ST_SCAN;
            end
         end
         lct_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = lct_pkg::ST_DRAIN;
            end
         end
         lct_pkg::ST_DRAIN: begin
            state_in = lct_pkg::ST_DECIDE;
         end
         lct_pkg::ST_DECIDE: begin
            if (status.hit) begin
               state_in = lct_pkg::ST_UPDATE;
            end else if (status.need_insert && status.need_evict) begin
               state_in = lct_pkg::ST_EVICT;
            end else if (status.need_insert) begin
               state_in = lct_pkg::ST_INSERT;
            end else begin
               state_in = lct_pkg::ST_IDLE;
               done_in  = 1'b1;
            end
         end
         lct_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = lct_pkg::ST_IDLE;
            done_in    = 1'b1;
         end
         lct_pkg::ST_EVICT: begin
            cmd.evict = 1'b1;
            state_in  = lct_pkg::ST_INSERT;
         end
         lct_pkg::ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = lct_pkg::ST_IDLE;
            done_in    = 1'b1;
         end
         default: begin
            state_in = lct_pkg::ST_IDLE;
            done_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lct_pkg::ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign req_stall = (state_ff != lct_pkg::ST_IDLE) || done_ff;
   assign done      = done_ff;

endmodule

FILE: rtl/lct_datapath.sv
// ----------------------------------------------------------------------------
// LFU cache table datapath
// Entry memory, valid bits, scan compare, counters and result register.
// ----------------------------------------------------------------------------
`include "lfu_cache_table_assert.svh"

module lct_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_cmd,
   input  logic [lct_pkg::KEY_W-1:0]           req_key,
   input  logic [lct_pkg::VALUE_W-1:0]         req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [lct_pkg::VALUE_W-1:0]         rsp_read_value,
   input  logic                                csr_wr_en,
   input  logic [lct_pkg::CAP_W-1:0]           csr_wr_data,
   input  lct_pkg::ctrl_cmd_type               cmd,
   output lct_pkg::ctrl_status_type            status
);

   lct_pkg::entry_type entry_mem [lct_pkg::TABLE_DEPTH];

   logic [lct_pkg::TABLE_DEPTH-1:0] valid_ff;
   logic [lct_pkg::OCC_W-1:0]       occupancy_ff;
   logic [lct_pkg::STAMP_W-1:0]     clock_ff;
   logic [lct_pkg::CAP_W-1:0]       capacity_ff;

   logic                            cmd_ff;
   logic [lct_pkg::KEY_W-1:0]       key_ff;
   logic [lct_pkg::VALUE_W-1:0]     value_ff;

   logic [lct_pkg::IDX_W-1:0]       scan_addr_ff;
   logic                            rd_pend_ff;
   logic [lct_pkg::IDX_W-1:0]       rd_idx_ff;
   lct_pkg::entry_type              rd_rec_ff;

   logic                            match_found_ff;
   logic [lct_pkg::IDX_W-1:0]       match_idx_ff;
   lct_pkg::entry_type              match_rec_ff;

   logic                            victim_found_ff;
   logic [lct_pkg::IDX_W-1:0]       victim_idx_ff;
   logic [lct_pkg::COUNT_W-1:0]     best_count_ff;
   logic [lct_pkg::STAMP_W-1:0]     best_stamp_ff;

   logic                            rsp_valid_ff;
   logic                            rsp_hit_ff;
   logic [lct_pkg::VALUE_W-1:0]     rsp_read_value_ff;

   logic [lct_pkg::LIM_W-1:0]       limit;
   logic                            rd_live;
   logic                            better;
   logic                            free_found;
   logic [lct_pkg::IDX_W-1:0]       free_idx;
   logic [lct_pkg::STAMP_W-1:0]     next_stamp;
   logic                            mem_we;
   logic [lct_pkg::IDX_W-1:0]       mem_waddr;
   lct_pkg::entry_type              mem_wdata;
   logic                            ins_fire;

   always_comb begin
      if (lct_pkg::LIM_W'(capacity_ff) < lct_pkg::LIM_W'(lct_pkg::TABLE_DEPTH)) begin
         limit = lct_pkg::LIM_W'(capacity_ff);
      end else begin
         limit = lct_pkg::LIM_W'(lct_pkg::TABLE_DEPTH);
      end
   end

   assign rd_live = rd_pend_ff && valid_ff[rd_idx_ff];
   assign better  = !victim_found_ff || (rd_rec_ff.count < best_count_ff) ||
                    ((rd_rec_ff.count == best_count_ff) && (rd_rec_ff.stamp < best_stamp_ff));

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = lct_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = lct_pkg::IDX_W'(i);
         end
      end
   end

   assign next_stamp = clock_ff + lct_pkg::STAMP_W'(1);
   assign ins_fire   = cmd.insert && free_found;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = match_idx_ff;
      mem_wdata = match_rec_ff;
      if (cmd.update) begin
         mem_we = 1'b1;
         if (match_rec_ff.count != '1) begin
            mem_wdata.count = match_rec_ff.count + lct_pkg::COUNT_W'(1);
         end
         mem_wdata.stamp = next_stamp;
         if (cmd_ff == lct_pkg::CMD_PUT) begin
            mem_wdata.value = value_ff;
         end
      end else if (ins_fire) begin
         mem_we          = 1'b1;
         mem_waddr       = free_idx;
         mem_wdata.key   = key_ff;
         mem_wdata.value = value_ff;
         mem_wdata.count = lct_pkg::COUNT_W'(1);
         mem_wdata.stamp = next_stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_rec_ff <= entry_mem[scan_addr_ff];
      rd_idx_ff <= scan_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff   <= req_cmd;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (rd_live && !match_found_ff && (rd_rec_ff.key == key_ff)) begin
         match_idx_ff <= rd_idx_ff;
         match_rec_ff <= rd_rec_ff;
      end
      if (rd_live && better) begin
         victim_idx_ff <= rd_idx_ff;
         best_count_ff <= rd_rec_ff.count;
         best_stamp_ff <= rd_rec_ff.stamp;
      end
      if (cmd.load_rsp) begin
         rsp_hit_ff <= match_found_ff;
         if (match_found_ff && (cmd_ff == lct_pkg::CMD_GET)) begin
            rsp_read_value_ff <= match_rec_ff.value;
         end else begin
            rsp_read_value_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= '0;
         occupancy_ff    <= '0;
         clock_ff        <= '0;
         capacity_ff     <= lct_pkg::CAPACITY_RESET;
         scan_addr_ff    <= '0;
         rd_pend_ff      <= 1'b0;
         match_found_ff  <= 1'b0;
         victim_found_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.scan;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (cmd.load_req) begin
            scan_addr_ff    <= '0;
            match_found_ff  <= 1'b0;
            victim_found_ff <= 1'b0;
         end else begin
            if (cmd.scan) begin
               scan_addr_ff <= scan_addr_ff + lct_pkg::IDX_W'(1);
            end
            if (rd_live && (rd_rec_ff.key == key_ff)) begin
               match_found_ff <= 1'b1;
            end
            if (rd_live) begin
               victim_found_ff <= 1'b1;
            end
         end
         if (cmd.update) begin
            clock_ff <= next_stamp;
         end
         if (cmd.evict) begin
            valid_ff[victim_idx_ff] <= 1'b0;
            occupancy_ff            <= occupancy_ff - lct_pkg::OCC_W'(1);
         end
         if (ins_fire) begin
            valid_ff[free_idx] <= 1'b1;
            occupancy_ff       <= occupancy_ff + lct_pkg::OCC_W'(1);
            clock_ff           <= next_stamp;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.scan_last   = scan_addr_ff == lct_pkg::IDX_W'(lct_pkg::TABLE_DEPTH - 1);
   assign status.hit         = match_found_ff;
   assign status.need_insert = (cmd_ff == lct_pkg::CMD_PUT) && (limit != '0);
   assign status.need_evict  = (lct_pkg::LIM_W'(occupancy_ff) >= limit) && victim_found_ff;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;

   `LCT_ASSERT_ALWAYS(a_occ_matches_valid, clock, reset, $countones(valid_ff) == occupancy_ff, "occupancy disagrees with valid bits")
   `LCT_ASSERT_IMPLY(a_update_needs_match, clock, reset, cmd.update, match_found_ff, "update without a matching entry")
   `LCT_ASSERT_IMPLY(a_evict_needs_victim, clock, reset, cmd.evict, victim_found_ff && valid_ff[victim_idx_ff], "evict without a valid victim")
   `LCT_ASSERT_NEXT(a_insert_sets_slot, clock, reset, ins_fire, valid_ff[$past(free_idx)], "inserted slot not marked valid")

endmodule

FILE: rtl/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// LFU cache table
// Sixteen-entry key/value table, least-frequently-used replacement with
// least-recently-used tie-break.
// ----------------------------------------------------------------------------
// Each request scans the table, then passes a drain, a decision step, the
// table write and the result load. The entry memory has one read port and
// is swept one entry per cycle, all 16 entries in each scan. The table
// write is an update on a hit, an insert for a put of a new key, an evict
// then an insert when that put must evict first, and nothing for a get
// miss or a put of a new key at zero capacity. The next request is taken
// once the result is loaded into the output register, so results may wait
// under rsp_stall while the following request is already transferred.
// The capacity register (reset 16, values above 16 act as 16) is written
// with csr_wr_en and must only be changed while the block is idle. On a put
// of a new key with the table at capacity, the entry with the lowest use
// count, and among those the oldest use, is dropped before the insert.
// ----------------------------------------------------------------------------
module lfu_cache_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cmd,
   input  logic [lct_pkg::KEY_W-1:0]   req_key,
   input  logic [lct_pkg::VALUE_W-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_hit,
   output logic [lct_pkg::VALUE_W-1:0] rsp_read_value,
   input  logic                        csr_wr_en,
   input  logic [lct_pkg::CAP_W-1:0]   csr_wr_data
);

   lct_pkg::ctrl_cmd_type    cmd;
   lct_pkg::ctrl_status_type status;
   logic                     done;
   logic                     ctrl_stall;

   lct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (ctrl_stall),
      .status    (status),
      .cmd       (cmd),
      .done      (done)
   );

   lct_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd            (cmd),
      .status         (status)
   );

   assign req_stall = ctrl_stall || (done && !status.out_free);

endmodule

FILE: tb/lfu_cache_table_checker.sv
// ----------------------------------------------------------------------------
// LFU cache table checker
// Watches the request, result and capacity ports. It keeps its own copy of
// the table and predicts hit and read value for every request transfer. Each
// result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lfu_cache_table_checker
   import lct_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_cmd,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_hit,
   input  logic [VALUE_W-1:0] rsp_read_value,
   input  logic               csr_wr_en,
   input  logic [CAP_W-1:0]   csr_wr_data,
   output int                 fail_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] read_value;
   } lookup_result_type;

   logic               tbl_valid [TABLE_DEPTH];
   logic [KEY_W-1:0]   tbl_key   [TABLE_DEPTH];
   logic [VALUE_W-1:0] tbl_value [TABLE_DEPTH];
   logic [COUNT_W-1:0] tbl_count [TABLE_DEPTH];
   logic [STAMP_W-1:0] tbl_stamp [TABLE_DEPTH];
   logic [STAMP_W-1:0] use_clock;
   logic [CAP_W-1:0]   cap_reg;
   int                 fill_level;
   int                 errors = 0;
   lookup_result_type  expected_q [$];

   function automatic void touch_slot(int s);
      use_clock    = use_clock + 1'b1;
      tbl_stamp[s] = use_clock;
   endfunction

   function automatic lookup_result_type apply_op(logic cmd, logic [KEY_W-1:0] k,
                                                  logic [VALUE_W-1:0] v);
      lookup_result_type res;
      int slot;
      int victim;
      int limit;
      res    = '0;
      slot   = -1;
      victim = -1;
      limit  = (cap_reg < TABLE_DEPTH) ? int'(cap_reg) : TABLE_DEPTH;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (slot < 0 && tbl_valid[i] && tbl_key[i] == k)
            slot = i;
      if (slot >= 0) begin
         res.hit = 1'b1;
         if (tbl_count[slot] != '1)
            tbl_count[slot] = tbl_count[slot] + 1'b1;
         touch_slot(slot);
         if (cmd == CMD_GET)
            res.read_value = tbl_value[slot];
         else
            tbl_value[slot] = v;
      end else if (cmd == CMD_PUT && limit != 0) begin
         if (fill_level >= limit) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (tbl_valid[i] && (victim < 0 || tbl_count[i] < tbl_count[victim] ||
                   (tbl_count[i] == tbl_count[victim] &&
                    tbl_stamp[i] < tbl_stamp[victim])))
                  victim = i;
            if (victim >= 0) begin
               tbl_valid[victim] = 1'b0;
               fill_level--;
            end
         end
         for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot < 0 && !tbl_valid[i])
               slot = i;
         if (slot >= 0) begin
            tbl_valid[slot] = 1'b1;
            tbl_key[slot]   = k;
            tbl_value[slot] = v;
            tbl_count[slot] = COUNT_W'(1);
            touch_slot(slot);
            fill_level++;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      lookup_result_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
            tbl_count[i] = '0;
            tbl_stamp[i] = '0;
         end
         use_clock  = '0;
         cap_reg    = CAPACITY_RESET;
         fill_level = 0;
         expected_q.delete();
      end else begin
         if (csr_wr_en)
            cap_reg = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result transfer: hit %0d read_value 0x%0h",
                      rsp_hit, rsp_read_value);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, actual %0d", want.hit, rsp_hit);
                  errors++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected 0x%0h, actual 0x%0h",
                         want.read_value, rsp_read_value);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(apply_op(req_cmd, req_key, req_value));
      end
      fail_count    <= errors;
      pending_count <= expected_q.size();
   end

endmodule

FILE: tb/tb_lfu_cache_table.sv
// ----------------------------------------------------------------------------
// LFU cache table testbench
// Drives gets and puts in random bursts against a random result stall, over
// a series of capacity settings written while the table is idle. A short
// directed part covers empty, eviction, zero and oversized capacity; random
// traffic from a small key pool keeps hits, updates and evictions frequent.
// ----------------------------------------------------------------------------
module tb_lfu_cache_table;
   timeunit 1ns;
   timeprecision 1ps;
   import lct_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int POOL_SIZE   = 24;
   localparam int NUM_PHASES  = 10;
   localparam int PHASE_ITEMS = 70;
   localparam logic [CAP_W-1:0] PHASE_CAPS [NUM_PHASES] =
      '{5'd1, 5'd3, 5'd16, 5'd0, 5'd7, 5'd31, 5'd2, 5'd12, 5'd16, 5'd5};

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic               req_cmd        = CMD_GET;
   logic [KEY_W-1:0]   req_key        = '0;
   logic [VALUE_W-1:0] req_value      = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic               rsp_hit;
   logic [VALUE_W-1:0] rsp_read_value;
   logic               csr_wr_en      = 1'b0;
   logic [CAP_W-1:0]   csr_wr_data    = '0;

   int                 fail_count;
   int                 pending_count;
   int                 cycle_count    = 0;
   int                 burst_left     = 0;
   int                 stall_left     = 0;
   int                 stall_mode     = 0;
   logic [KEY_W-1:0]   key_pool [POOL_SIZE];

   lfu_cache_table i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   lfu_cache_table_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_lfu_cache_table: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(8, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   task automatic send_op(input logic cmd, input logic [KEY_W-1:0] k,
                          input logic [VALUE_W-1:0] v);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_key   <= k;
      req_value <= v;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      drain_all();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [KEY_W-1:0]   k;
      logic [VALUE_W-1:0] v;
      int                 span;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;

      send_op(CMD_GET, 32'h0000_0000, 31'h0);
      send_op(CMD_PUT, 32'h0000_0000, 31'h7FFF_FFFF);
      send_op(CMD_GET, 32'h0000_0000, 31'h0);
      send_op(CMD_PUT, 32'hFFFF_FFFF, 31'h0);
      send_op(CMD_GET, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      send_op(CMD_PUT, 32'h0000_0000, 31'h2AAA_AAAA);
      write_capacity(5'd2);
      send_op(CMD_PUT, 32'h0000_0005, 31'h5555_5555);
      send_op(CMD_GET, 32'hFFFF_FFFF, 31'h0);
      send_op(CMD_GET, 32'h0000_0005, 31'h0);
      write_capacity(5'd0);
      send_op(CMD_PUT, 32'h0000_0007, 31'h1234_5678);
      send_op(CMD_GET, 32'h0000_0007, 31'h0);
      send_op(CMD_GET, 32'h0000_0000, 31'h0);
      send_op(CMD_PUT, 32'h0000_0005, 31'h1);
      write_capacity(5'd31);
      for (int i = 0; i < 15; i++)
         send_op(CMD_PUT, 32'h0000_0100 + i, VALUE_W'(i));

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_capacity(PHASE_CAPS[p]);
         span = $urandom_range(2, POOL_SIZE);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) == 0)
               k = $urandom;
            else
               k = key_pool[$urandom_range(0, span - 1)];
            case ($urandom_range(0, 7))
               0: v = '0;
               1: v = '1;
               default: v = VALUE_W'($urandom);
            endcase
            send_op(($urandom_range(0, 1) == 1) ? CMD_PUT : CMD_GET, k, v);
         end
      end

      drain_all();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("tb_lfu_cache_table: done, clean");
      else
         $display("tb_lfu_cache_table: done, errors");
      $finish;
   end

endmodule
